// ===== src/sacc_pkg.sv =====
// Shared types and codes for the short-key associative cache.
package sacc_pkg;

  localparam int unsigned LEN_W    = 4;
  localparam int unsigned RAW_W    = 64;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 3;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_REJECTED = 2'd3
  } sacc_status_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } sacc_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } sacc_state_t;

endpackage

// ===== src/sacc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sacc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/short_key_associative_cache_core.sv =====
// Top level of the short-key associative cache: control, slot picking and scan.
//
// Usage:
//   Drive in_* and raise start; the item transfers at a clock edge where start
//   is high and busy is low. Each item yields exactly one result, shown on
//   out_* for one cycle with out_valid high; the receiver cannot stall it.
//   Inserts, rejected key lengths and lookups into an empty cache answer in the
//   cycle after the transfer and leave busy low, so such items may follow
//   back to back. A lookup walks the slot RAM one slot per cycle, starting at
//   slot 0 and comparing each slot's registered read data: it holds busy high
//   and answers on the first matching slot, or after the last slot on a miss.
//   The single read port of the slot RAM sets that pace. Keys and values live
//   in the RAM, used bits, age bits and the start slot in flops.
//   Reset (rst_n low, synchronous) empties all slots and clears the age bits
//   and the start slot; the RAM itself is not cleared.
module short_key_associative_cache_core
  import sacc_pkg::*;
#(
  parameter int unsigned SLOT_COUNT    = 8,
  parameter int unsigned KEY_BYTES_MAX = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [LEN_W-1:0]   in_key_length,
  input  logic [RAW_W-1:0]   in_key_bytes,
  input  logic [VALUE_W-1:0] in_insert_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [VALUE_W-1:0] out_found_value,
  output logic [SLOT_W-1:0]  out_slot_index
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned KEY_W  = 8 * KEY_BYTES_MAX;
  localparam int unsigned DATA_W = KEY_W + VALUE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  sacc_state_t             state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   used_r, used_nxt;
  logic [SLOT_COUNT-1:0]   age_r, age_nxt;
  logic [IDX_W-1:0]        start_r, start_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        chk_idx_r, chk_idx_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sacc_status_t            out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]      out_value_r, out_value_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;

  logic                    accept;
  logic                    len_ok;
  logic [KEY_W-1:0]        key_pack;
  logic [IDX_W-1:0]        low_empty;
  logic [IDX_W-1:0]        high_fresh;
  logic [IDX_W-1:0]        ins_pick;
  logic [IDX_W-1:0]        ram_raddr;
  logic                    ram_we;
  logic [DATA_W-1:0]       ram_rdata;
  logic [KEY_W-1:0]        rd_key;
  logic [VALUE_W-1:0]      rd_val;
  logic                    hit_now;
  logic                    last_chk;

  assign accept = start && !busy;
  assign len_ok = (in_key_length != '0) && (in_key_length <= LEN_W'(KEY_BYTES_MAX));

  always_comb begin
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      key_pack[8*b +: 8] = (LEN_W'(b) < in_key_length) ? in_key_bytes[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    low_empty  = '0;
    high_fresh = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        low_empty = IDX_W'(i);
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!age_r[i]) begin
        high_fresh = IDX_W'(i);
      end
    end
    if (!(&used_r)) begin
      ins_pick = low_empty;
    end else if (!(&age_r)) begin
      ins_pick = high_fresh;
    end else if (start_r == LAST_IDX) begin
      ins_pick = '0;
    end else begin
      ins_pick = start_r + 1'b1;
    end
  end

  sacc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_pick),
    .wdata ({in_insert_value, key_pack}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[KEY_W-1:0];
  assign rd_val   = ram_rdata[DATA_W-1:KEY_W];
  assign hit_now  = chk_vld_r && used_r[chk_idx_r] && (rd_key == key_r);
  assign last_chk = chk_vld_r && (chk_idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept && len_ok && (in_operation == OP_LOOKUP) && (used_r != '0)) begin
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit_now || last_chk) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = idx_r;
    unique case (state_r)
      FSM_IDLE: begin
        ram_we = start && len_ok && (in_operation == OP_INSERT);
      end
      FSM_SCAN: begin
        busy = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    used_nxt       = used_r;
    age_nxt        = age_r;
    start_nxt      = start_r;
    idx_nxt        = idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;
    if (accept) begin
      if (!len_ok) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_REJECTED;
        out_value_nxt  = '0;
        out_slot_nxt   = '0;
      end else if (in_operation == OP_INSERT) begin
        used_nxt       = used_r | (SLOT_COUNT'(1) << ins_pick);
        age_nxt        = (SLOT_COUNT'(1) << start_r) | (SLOT_COUNT'(1) << ins_pick);
        start_nxt      = ins_pick;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_INSERTED;
        out_value_nxt  = '0;
        out_slot_nxt   = SLOT_W'(ins_pick);
      end else if (used_r == '0) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_MISS;
        out_value_nxt  = '0;
        out_slot_nxt   = '0;
      end else begin
        key_nxt     = key_pack;
        idx_nxt     = '0;
        chk_vld_nxt = 1'b0;
      end
    end
    if (state_r == FSM_SCAN) begin
      chk_vld_nxt = 1'b1;
      chk_idx_nxt = idx_r;
      if (idx_r != LAST_IDX) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (hit_now) begin
        age_nxt        = age_r | (SLOT_COUNT'(1) << chk_idx_r);
        start_nxt      = chk_idx_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_HIT;
        out_value_nxt  = rd_val;
        out_slot_nxt   = SLOT_W'(chk_idx_r);
      end else if (last_chk) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_MISS;
        out_value_nxt  = '0;
        out_slot_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      used_r      <= '0;
      age_r       <= '0;
      start_r     <= '0;
      idx_r       <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      age_r       <= age_nxt;
      start_r     <= start_nxt;
      idx_r       <= idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_slot_index  = out_slot_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_HIT)) |->
      (used_r[out_slot_index[IDX_W-1:0]] && age_r[out_slot_index[IDX_W-1:0]]))
    else $error("hit reported on a slot that is not used and aged");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_INSERTED)) |->
      (($countones(age_r) <= 2) && used_r[out_slot_index[IDX_W-1:0]]
       && (start_r == out_slot_index[IDX_W-1:0])))
    else $error("insert left inconsistent age, used or start state");

  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == FSM_IDLE))
    else $error("slot RAM written during a scan");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("transfer produced neither a scan nor a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_valid) |-> $past(start && !busy))
    else $error("result shown during a scan without a preceding transfer");
`endif

endmodule
